### rtl/assert_macros.svh
// assertion macros used by the sampler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define JMRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define JMRS_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### rtl/jmrs_pkg.sv
// types and constants of the joint marginal roulette sampler
package jmrs_pkg;

  localparam int BINS_DEF = 16;
  localparam int WEIGHT_W = 16;
  localparam int RAND_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int MASK_W   = 16;
  localparam int IDX_W    = 4;
  localparam int STAT_W   = 2;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    logic                action;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [WEIGHT_W-1:0] weight;
    logic [RAND_W-1:0]   rand_first;
    logic [RAND_W-1:0]   rand_second;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  first_bin;
    logic [IDX_W-1:0]  second_bin;
    logic [STAT_W-1:0] status;
  } out_word_t;

endpackage

### rtl/joint_marginal_roulette_sampler_top.sv
// top level of the joint marginal roulette sampler
//
// channel   dir  handshake                   word
// in        in   in_valid_i / in_stall_o     in_word_i  (write weight or sample request)
// out       out  out_valid_o / out_stall_i   out_word_o (bins and status, one per sample)
// cfg       in   cfg_we_i                    cfg_wdata_i (occupancy mask)
//
// a weight write reads the weight and both sum memories, then writes them back
// a sample runs a totals scan, a multiply, a selection scan, then the result
// an all-zero matrix answers a sample without the scans
// after reset a clearing pass over every weight address zeroes the
//   memories; no word is taken meanwhile, config writes are
// a result waits in the output register; a sample done behind it holds and stalls the input
module joint_marginal_roulette_sampler_top
  import jmrs_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic [MASK_W-1:0] cfg_wdata_i
);

  `include "assert_macros.svh"

  // widths derived from the bin count
  localparam int BIN_W  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int WA_W   = 2 * BIN_W;            // weight address is {row, col}
  localparam int SDEPTH = 1 << BIN_W;
  localparam int WDEPTH = 1 << WA_W;
  localparam int SUM_W  = WEIGHT_W + BIN_W;     // one row or column sum
  localparam int TOT_W  = WEIGHT_W + 2 * BIN_W; // grand total and masked totals
  localparam int PROD_W = RAND_W + TOT_W;       // r * total, and cum << 16

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR,
    ST_P1,
    ST_P1_END,
    ST_MUL,
    ST_P2,
    ST_P2_END,
    ST_RES
  } state_e;

  state_e             state_q;
  logic [WA_W-1:0]    clr_q;
  logic [BIN_W-1:0]   idx_q;
  logic [BIN_W-1:0]   acc_idx_q;
  logic               acc1_q;     // sum read data valid, totals pass
  logic               acc2_q;     // sum read data valid, selection pass
  in_word_t           item_q;
  logic [TOT_W-1:0]   tot_q;
  logic [MASK_W-1:0]  mask_q;
  logic [TOT_W-1:0]   m1_q, m2_q;
  logic               m1_nz_q, m2_nz_q;
  logic [PROD_W-1:0]  prod1_q, prod2_q;
  logic [TOT_W-1:0]   cum1_q, cum2_q;
  logic               found1_q, found2_q;
  logic               empty1_q, empty2_q;
  logic [BIN_W-1:0]   first_q, second_q;
  logic               zero_q;
  logic               out_valid_q;
  out_word_t          out_word_q;

  // memories
  logic [WEIGHT_W-1:0] w_mem [WDEPTH];
  logic [SUM_W-1:0]    rs_mem [SDEPTH];
  logic [SUM_W-1:0]    cs_mem [SDEPTH];
  logic [WEIGHT_W-1:0] w_rd_q;
  logic [SUM_W-1:0]    rs_rd_q, cs_rd_q;

  logic                w_we, s_we;
  logic [WA_W-1:0]     w_wa, w_ra;
  logic [WEIGHT_W-1:0] w_wd;
  logic [BIN_W-1:0]    rs_wa, cs_wa, rs_ra, cs_ra;
  logic [SUM_W-1:0]    rs_wd, cs_wd, rs_new, cs_new;
  logic [TOT_W-1:0]    tot_new;

  logic                in_acc, in_range;
  logic [31:0]         acc_idx_ext;
  logic                occ;
  logic [TOT_W-1:0]    rs_add, cs_add, cum1_new, cum2_new;
  logic [PROD_W-1:0]   cum1_sh, cum2_sh;
  logic                hit1, hit2;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(in_word_i.row) < BINS) && (32'(in_word_i.col) < BINS);

  // read addresses: sums take the incoming word while idle, the scan index otherwise; weights always the word
  always_comb begin
    w_ra  = {BIN_W'(in_word_i.row), BIN_W'(in_word_i.col)};
    rs_ra = idx_q;
    cs_ra = idx_q;
    if (state_q == ST_IDLE) begin
      rs_ra = BIN_W'(in_word_i.row);
      cs_ra = BIN_W'(in_word_i.col);
    end
  end

  // read-modify-write of one weight: replace old value in both sums and the total
  assign rs_new  = rs_rd_q - SUM_W'(w_rd_q) + SUM_W'(item_q.weight);
  assign cs_new  = cs_rd_q - SUM_W'(w_rd_q) + SUM_W'(item_q.weight);
  assign tot_new = tot_q - TOT_W'(w_rd_q) + TOT_W'(item_q.weight);

  // write port: clearing sweep or weight write-back
  always_comb begin
    w_we  = (state_q == ST_CLEAR) || (state_q == ST_WR);
    s_we  = w_we;
    w_wa  = {BIN_W'(item_q.row), BIN_W'(item_q.col)};
    w_wd  = item_q.weight;
    rs_wa = BIN_W'(item_q.row);
    cs_wa = BIN_W'(item_q.col);
    rs_wd = rs_new;
    cs_wd = cs_new;
    if (state_q == ST_CLEAR) begin
      w_wa  = clr_q;
      w_wd  = '0;
      rs_wa = clr_q[BIN_W-1:0];
      cs_wa = clr_q[BIN_W-1:0];
      rs_wd = '0;
      cs_wd = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_wa] <= w_wd;
    end
    w_rd_q <= w_mem[w_ra];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      rs_mem[rs_wa] <= rs_wd;
      cs_mem[cs_wa] <= cs_wd;
    end
    rs_rd_q <= rs_mem[rs_ra];
    cs_rd_q <= cs_mem[cs_ra];
  end

  // bins beyond the mask width always count as occupied
  assign acc_idx_ext = 32'(acc_idx_q);
  assign occ = (acc_idx_ext < 32'd16) ? mask_q[acc_idx_ext[3:0]] : 1'b1;

  assign rs_add   = occ ? TOT_W'(rs_rd_q) : '0;
  assign cs_add   = occ ? TOT_W'(cs_rd_q) : '0;
  assign cum1_new = cum1_q + rs_add;
  assign cum2_new = cum2_q + cs_add;
  assign cum1_sh  = {cum1_new, FRAC_W'(0)};
  assign cum2_sh  = {cum2_new, FRAC_W'(0)};
  // first bin uses a strict compare, second bin includes equality
  assign hit1 = m1_nz_q && (prod1_q < cum1_sh);
  assign hit2 = m2_nz_q && (prod2_q <= cum2_sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      acc_idx_q   <= '0;
      acc1_q      <= 1'b0;
      acc2_q      <= 1'b0;
      tot_q       <= '0;
      mask_q      <= '1;
      found1_q    <= 1'b0;
      found2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      // the result state reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_RES)) begin
        out_valid_q <= 1'b0;
      end

      // read data of the scans arrives in the cycle after the address
      acc1_q    <= (state_q == ST_P1);
      acc2_q    <= (state_q == ST_P2);
      acc_idx_q <= idx_q;

      if (acc1_q) begin
        m1_q <= m1_q + rs_add;
        m2_q <= m2_q + cs_add;
      end
      if (acc2_q) begin
        cum1_q <= cum1_new;
        cum2_q <= cum2_new;
        if (hit1 && !found1_q) begin
          found1_q <= 1'b1;
          first_q  <= acc_idx_q;
          empty1_q <= (rs_rd_q == '0);
        end
        if (hit2 && !found2_q) begin
          found2_q <= 1'b1;
          second_q <= acc_idx_q;
          empty2_q <= (cs_rd_q == '0);
        end
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            item_q <= in_word_i;
            if (in_word_i.action == ACT_SAMPLE) begin
              m1_q     <= '0;
              m2_q     <= '0;
              cum1_q   <= '0;
              cum2_q   <= '0;
              found1_q <= 1'b0;
              found2_q <= 1'b0;
              empty1_q <= 1'b0;
              empty2_q <= 1'b0;
              first_q  <= '0;
              second_q <= '0;
              idx_q    <= '0;
              zero_q   <= (tot_q == '0);
              state_q  <= (tot_q == '0) ? ST_RES : ST_P1;
            end else if (in_range) begin
              state_q <= ST_WR;
            end
          end
        end
        ST_WR: begin
          tot_q   <= tot_new;
          state_q <= ST_IDLE;
        end
        ST_P1: begin
          if (32'(idx_q) == BINS - 1) begin
            idx_q   <= '0;
            state_q <= ST_P1_END;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_P1_END: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod1_q <= PROD_W'(item_q.rand_first) * PROD_W'(m1_q);
          prod2_q <= PROD_W'(item_q.rand_second) * PROD_W'(m2_q);
          m1_nz_q <= (m1_q != '0);
          m2_nz_q <= (m2_q != '0);
          state_q <= ST_P2;
        end
        ST_P2: begin
          if (32'(idx_q) == BINS - 1) begin
            idx_q   <= '0;
            state_q <= ST_P2_END;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_P2_END: begin
          state_q <= ST_RES;
        end
        ST_RES: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q           <= 1'b1;
            out_word_q.first_bin  <= IDX_W'(first_q);
            out_word_q.second_bin <= IDX_W'(second_q);
            if (zero_q) begin
              out_word_q.status <= STAT_ZERO;
            end else if (!found1_q || !found2_q) begin
              out_word_q.status <= STAT_NONE;
            end else if (empty1_q || empty2_q) begin
              out_word_q.status <= STAT_EMPTY;
            end else begin
              out_word_q.status <= STAT_OK;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `JMRS_ASSERT(a_out_from_res, $rose(out_valid_q) |-> $past(state_q == ST_RES),
    "result word raised outside the result state")
  `JMRS_ASSERT(a_total_only_on_write, (state_q != ST_WR) |=> $stable(tot_q),
    "grand total changed without a weight write")
  `JMRS_ASSERT(a_pick_in_scan, $rose(found1_q) |-> $past(acc2_q && m1_nz_q),
    "first bin picked outside the selection scan")
  `JMRS_ASSERT_NEVER(a_scan_idx_range, (acc1_q || acc2_q) && (acc_idx_ext >= BINS),
    "scan index beyond the bin count")

endmodule
